[hw/rtl/qoa_pkg.sv]
`timescale 1ns / 1ps

package qoa_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int SLICES_PER_FRAME  = 256;
    localparam int SAMPLES_PER_SLICE = 20;

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int FCH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int GRP_W  = $clog2(SLICES_PER_FRAME + 1);
    localparam int K_W    = $clog2(SAMPLES_PER_SLICE + 1);
    localparam int SEEN_W = 18;
    localparam int LIM_W  = 20;

    // byte budget per channel: two lms words plus a full run of slices
    localparam int LIMIT_STEP = 16 + 8 * SLICES_PER_FRAME;

    localparam logic [31:0] FILE_MAGIC = 32'h716F6166;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_FRAME    = 3'd2;
    localparam logic [2:0] ERR_CHANNELS = 3'd3;
    localparam logic [2:0] ERR_RATE     = 3'd4;

    typedef enum logic [1:0] {
        PH_FILE,
        PH_FRAME,
        PH_LMS,
        PH_SLICE
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_ACC,
        S_STORE
    } t_state;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         error_code;
        logic signed [15:0] sample;
        logic [2:0]         channel;
        logic [31:0]        position;
        logic               last;
        logic               finished;
    } t_result;

    // magnitudes for even quantizer codes; odd codes are the negatives
    localparam logic [15:0] DQ_MAG [16][4] = '{
        '{16'd1,    16'd3,    16'd5,    16'd7},
        '{16'd5,    16'd18,   16'd32,   16'd49},
        '{16'd16,   16'd53,   16'd95,   16'd147},
        '{16'd34,   16'd113,  16'd203,  16'd315},
        '{16'd63,   16'd210,  16'd378,  16'd588},
        '{16'd104,  16'd345,  16'd621,  16'd966},
        '{16'd158,  16'd528,  16'd950,  16'd1477},
        '{16'd228,  16'd760,  16'd1368, 16'd2128},
        '{16'd316,  16'd1053, 16'd1895, 16'd2947},
        '{16'd422,  16'd1405, 16'd2529, 16'd3934},
        '{16'd548,  16'd1828, 16'd3290, 16'd5117},
        '{16'd696,  16'd2320, 16'd4176, 16'd6496},
        '{16'd868,  16'd2893, 16'd5207, 16'd8099},
        '{16'd1064, 16'd3548, 16'd6386, 16'd9933},
        '{16'd1286, 16'd4288, 16'd7718, 16'd12005},
        '{16'd1536, 16'd5120, 16'd9216, 16'd14336}
    };

    function automatic logic signed [15:0] f_dequant(input logic [3:0] sf,
                                                     input logic [2:0] q);
        logic [15:0] mag;
        mag = DQ_MAG[sf][q[2:1]];
        return q[0] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[hw/rtl/qoa_stream_decoder.sv]
`timescale 1ns / 1ps

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------
// stream in | in        | push / full          | i_stream_word (64b, big-endian)
// result    | out       | empty / pop          | o_kind, o_error_code, o_sample,
//           |           |                      | o_channel, o_position, o_last,
//           |           |                      | o_finished
//
// header and lms words are handled directly in S_IDLE, without the lms unit
// a slice word goes through one shared 4-tap lms unit: S_LOAD, then per sample
//   an S_MUL multiply step and an S_ACC accumulate/saturate/update step, then S_STORE
// two-entry queues on both sides; the decoder stalls when the result queue is full
// reset is synchronous, active low; the per-channel lms stores are not cleared

module qoa_stream_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [63:0]        i_stream_word,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_kind,
    output logic [2:0]         o_error_code,
    output logic signed [15:0] o_sample,
    output logic [2:0]         o_channel,
    output logic [31:0]        o_position,
    output logic               o_last,
    output logic               o_finished
);
    import qoa_pkg::*;

    // front: incoming word queue
    logic        in_empty;
    logic        in_pop;
    logic [63:0] in_word;

    // back side result path
    logic        out_full;
    logic        out_push;
    t_result     out_res;
    t_result     head;

    qoa_inq u_inq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_stream_word),
        .o_full  (full),
        .i_pop   (in_pop),
        .o_data  (in_word),
        .o_empty (in_empty)
    );

    // parser plus lms decode engine
    qoa_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_empty (in_empty),
        .i_in_word  (in_word),
        .o_in_pop   (in_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_res  (out_res)
    );

    // results wait here until popped
    qoa_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty)
    );

    assign o_kind       = head.kind;
    assign o_error_code = head.error_code;
    assign o_sample     = head.sample;
    assign o_channel    = head.channel;
    assign o_position   = head.position;
    assign o_last       = head.last;
    assign o_finished   = head.finished;

endmodule

[hw/rtl/qoa_inq.sv]
`timescale 1ns / 1ps

module qoa_inq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [63:0] i_data,
    output logic        o_full,
    input  logic        i_pop,
    output logic [63:0] o_data,
    output logic        o_empty
);
    import qoa_pkg::*;

    logic [63:0] r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

[hw/rtl/qoa_outq.sv]
`timescale 1ns / 1ps

module qoa_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qoa_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output qoa_pkg::t_result o_data,
    output logic             o_empty
);
    import qoa_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

[hw/rtl/qoa_core.sv]
`timescale 1ns / 1ps

module qoa_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_empty,
    input  logic [63:0]      i_in_word,
    output logic             o_in_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output qoa_pkg::t_result o_out_res
);
    import qoa_pkg::*;

    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [31:0]         r_total, n_total;
    logic [31:0]         r_dec, n_dec;
    logic                r_lch_ok, n_lch_ok;
    logic [7:0]          r_lch, n_lch;
    logic                r_lrate_ok, n_lrate_ok;
    logic [23:0]         r_lrate, n_lrate;
    logic [FCH_W-1:0]    r_fch, n_fch;
    logic [15:0]         r_fbt, n_fbt;
    logic [SEEN_W-1:0]   r_seen, n_seen;
    logic [CH_W-1:0]     r_cur, n_cur;
    logic                r_half, n_half;
    logic [GRP_W-1:0]    r_grp, n_grp;

    // slice datapath
    logic [CH_W-1:0]     r_ch, n_ch;
    logic [31:0]         r_base, n_base;
    logic [K_W-1:0]      r_n, n_n;
    logic [K_W-1:0]      r_k, n_k;
    logic                r_fin, n_fin;
    logic [3:0]          r_sf, n_sf;
    logic [59:0]         r_q, n_q;
    logic signed [15:0]  r_h [4];
    logic signed [15:0]  n_h [4];
    logic signed [31:0]  r_w [4];
    logic signed [31:0]  n_w [4];
    logic signed [31:0]  r_prod [4];
    logic signed [31:0]  n_prod [4];

    logic signed [15:0]  r_hist [MAX_CHANNELS][4];
    logic signed [15:0]  n_hist [MAX_CHANNELS][4];
    logic signed [31:0]  r_wt [MAX_CHANNELS][4];
    logic signed [31:0]  n_wt [MAX_CHANNELS][4];

    function automatic logic [31:0] f_adv(input logic [31:0] d, input logic [31:0] t);
        logic [31:0] rem;
        rem = t - d;
        if (t != 32'd0 && rem < 32'(SAMPLES_PER_SLICE)) return t;
        return d + 32'(SAMPLES_PER_SLICE);
    endfunction

    always_comb begin
        logic [7:0]         ch;
        logic [23:0]        rate;
        logic [15:0]        nsamp;
        logic [15:0]        size;
        logic [LIM_W-1:0]   limit;
        logic [FCH_W-1:0]   cur1;
        logic [SEEN_W-1:0]  seen1;
        logic [GRP_W-1:0]   grp1;
        logic [31:0]        dec1;
        logic [CH_W-1:0]    curf;
        logic [31:0]        rem;
        logic               emit;
        logic signed [31:0] acc;
        logic signed [18:0] pred;
        logic signed [15:0] rq;
        logic signed [19:0] ssum;
        logic signed [15:0] sat;
        logic signed [31:0] dd;
        logic signed [47:0] mp;

        n_state = r_state;   n_phase = r_phase;   n_total = r_total;
        n_dec = r_dec;       n_lch_ok = r_lch_ok; n_lch = r_lch;
        n_lrate_ok = r_lrate_ok; n_lrate = r_lrate; n_fch = r_fch;
        n_fbt = r_fbt;       n_seen = r_seen;     n_cur = r_cur;
        n_half = r_half;     n_grp = r_grp;       n_ch = r_ch;
        n_base = r_base;     n_n = r_n;           n_k = r_k;
        n_fin = r_fin;       n_sf = r_sf;         n_q = r_q;
        n_h = r_h;           n_w = r_w;           n_prod = r_prod;
        n_hist = r_hist;     n_wt = r_wt;
        o_in_pop = 1'b0;
        o_out_push = 1'b0;
        o_out_res = '0;

        ch    = i_in_word[63:56];
        rate  = i_in_word[55:32];
        nsamp = i_in_word[31:16];
        size  = i_in_word[15:0];
        limit = LIM_W'(8) + LIM_W'(ch) * LIM_W'(LIMIT_STEP);
        cur1  = FCH_W'(r_cur) + FCH_W'(1);
        seen1 = r_seen + SEEN_W'(8);
        grp1  = r_grp;
        dec1  = r_dec;
        curf  = r_cur;
        rem   = r_total - r_dec;
        emit  = (r_k < r_n);
        acc   = r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
        pred  = acc[31:13];
        rq    = f_dequant(r_sf, r_q[59:57]);
        ssum  = 20'(rq) + 20'(pred);
        if (ssum > 20'sd32767)       sat = 16'sd32767;
        else if (ssum < -20'sd32768) sat = -16'sd32768;
        else                         sat = ssum[15:0];
        dd    = 32'(rq >>> 4);
        mp    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_in_empty && r_phase == PH_SLICE) begin
                    o_in_pop = 1'b1;
                    n_ch   = r_cur;
                    n_base = r_dec;
                    n_sf   = i_in_word[63:60];
                    n_q    = i_in_word[59:0];
                    n_k    = '0;
                    if (r_total == 32'd0)
                        n_n = K_W'(SAMPLES_PER_SLICE);
                    else if (rem < 32'(SAMPLES_PER_SLICE))
                        n_n = K_W'(rem);
                    else
                        n_n = K_W'(SAMPLES_PER_SLICE);
                    // frame bookkeeping is settled up front
                    if (cur1 >= r_fch) begin
                        curf = '0;
                        grp1 = r_grp + GRP_W'(1);
                        dec1 = f_adv(r_dec, r_total);
                    end else begin
                        curf = CH_W'(cur1);
                    end
                    if (grp1 >= GRP_W'(SLICES_PER_FRAME) ||
                        (seen1 + SEEN_W'(8)) > SEEN_W'(r_fbt)) begin
                        if (curf != '0) begin
                            dec1 = f_adv(dec1, r_total);
                            curf = '0;
                        end
                        n_phase = PH_FRAME;
                    end
                    n_cur  = curf;
                    n_grp  = grp1;
                    n_dec  = dec1;
                    n_seen = seen1;
                    n_fin  = (r_total != 32'd0) && (dec1 >= r_total);
                    n_state = S_LOAD;
                end else if (!i_in_empty && !i_out_full) begin
                    o_in_pop = 1'b1;
                    o_out_push = 1'b1;
                    o_out_res.last = 1'b1;
                    o_out_res.finished = (r_total != 32'd0) && (r_dec >= r_total);
                    unique case (r_phase)
                        PH_FILE: begin
                            if (i_in_word[63:32] != FILE_MAGIC) begin
                                o_out_res.kind = KIND_ERROR;
                                o_out_res.error_code = ERR_MAGIC;
                            end else begin
                                n_total = i_in_word[31:0];
                                n_dec = '0;
                                n_phase = PH_FRAME;
                                o_out_res.finished = 1'b0;
                            end
                        end
                        PH_FRAME: begin
                            if (ch == 8'd0 || rate == 24'd0 || nsamp == 16'd0 ||
                                LIM_W'(size) > limit || ch > 8'(MAX_CHANNELS)) begin
                                o_out_res.kind = KIND_ERROR;
                                o_out_res.error_code = ERR_FRAME;
                            end else if (r_lch_ok && r_lch != ch) begin
                                o_out_res.kind = KIND_ERROR;
                                o_out_res.error_code = ERR_CHANNELS;
                            end else begin
                                n_lch_ok = 1'b1;
                                n_lch = ch;
                                if (r_lrate_ok && r_lrate != rate) begin
                                    o_out_res.kind = KIND_ERROR;
                                    o_out_res.error_code = ERR_RATE;
                                end else begin
                                    n_lrate_ok = 1'b1;
                                    n_lrate = rate;
                                    n_fch = FCH_W'(ch);
                                    n_fbt = size;
                                    n_seen = SEEN_W'(8);
                                    n_cur = '0;
                                    n_half = 1'b0;
                                    n_grp = '0;
                                    n_phase = PH_LMS;
                                end
                            end
                        end
                        PH_LMS: begin
                            for (int j = 0; j < 4; j++) begin
                                if (!r_half)
                                    n_hist[r_cur][j] = i_in_word[63-16*j -: 16];
                                else
                                    n_wt[r_cur][j] = 32'(signed'(i_in_word[63-16*j -: 16]));
                            end
                            n_seen = seen1;
                            n_half = ~r_half;
                            if (r_half) begin
                                if (cur1 >= r_fch) begin
                                    n_cur = '0;
                                    n_grp = '0;
                                    n_phase = ((seen1 + SEEN_W'(8)) > SEEN_W'(r_fbt))
                                              ? PH_FRAME : PH_SLICE;
                                end else begin
                                    n_cur = CH_W'(cur1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_h = r_hist[r_ch];
                n_w = r_wt[r_ch];
                n_state = S_MUL;
            end
            S_MUL: begin
                for (int l = 0; l < 4; l++) begin
                    mp = r_w[l] * r_h[l];
                    n_prod[l] = mp[31:0];
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!emit || !i_out_full) begin
                    if (emit) begin
                        o_out_push = 1'b1;
                        o_out_res.kind = KIND_SAMPLE;
                        o_out_res.sample = sat;
                        o_out_res.channel = 3'(r_ch);
                        o_out_res.position = r_base + 32'(r_k);
                        o_out_res.last = (r_k == r_n - K_W'(1));
                        o_out_res.finished = r_fin;
                    end
                    for (int l = 0; l < 4; l++)
                        n_w[l] = r_h[l][15] ? (r_w[l] - dd) : (r_w[l] + dd);
                    n_h[0] = r_h[1];
                    n_h[1] = r_h[2];
                    n_h[2] = r_h[3];
                    n_h[3] = sat;
                    n_q = {r_q[56:0], 3'b000};
                    n_k = r_k + K_W'(1);
                    n_state = (r_k == K_W'(SAMPLES_PER_SLICE - 1)) ? S_STORE : S_MUL;
                end
            end
            S_STORE: begin
                if (r_n != '0 || !i_out_full) begin
                    if (r_n == '0) begin
                        o_out_push = 1'b1;
                        o_out_res.last = 1'b1;
                        o_out_res.finished = r_fin;
                    end
                    n_hist[r_ch] = r_h;
                    n_wt[r_ch] = r_w;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_FILE;
            r_total    <= '0;
            r_dec      <= '0;
            r_lch_ok   <= 1'b0;
            r_lrate_ok <= 1'b0;
            r_fch      <= '0;
            r_fbt      <= '0;
            r_seen     <= '0;
            r_cur      <= '0;
            r_half     <= 1'b0;
            r_grp      <= '0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_total    <= n_total;
            r_dec      <= n_dec;
            r_lch_ok   <= n_lch_ok;
            r_lrate_ok <= n_lrate_ok;
            r_fch      <= n_fch;
            r_fbt      <= n_fbt;
            r_seen     <= n_seen;
            r_cur      <= n_cur;
            r_half     <= n_half;
            r_grp      <= n_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lch   <= n_lch;
        r_lrate <= n_lrate;
        r_ch    <= n_ch;
        r_base  <= n_base;
        r_n     <= n_n;
        r_k     <= n_k;
        r_fin   <= n_fin;
        r_sf    <= n_sf;
        r_q     <= n_q;
        r_h     <= n_h;
        r_w     <= n_w;
        r_prod  <= n_prod;
        r_hist  <= n_hist;
        r_wt    <= n_wt;
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> !i_out_full)
        else $error("result pushed into full queue");
    a_sample_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && o_out_res.kind == KIND_SAMPLE) |-> (r_state == S_ACC && r_k < r_n))
        else $error("sample emitted outside decode step");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_ACC) |-> r_k < K_W'(SAMPLES_PER_SLICE))
        else $error("sample counter out of range");
    a_fch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LMS || r_phase == PH_SLICE) |->
            (r_fch != '0 && r_fch <= FCH_W'(MAX_CHANNELS) && FCH_W'(r_cur) < r_fch))
        else $error("frame channel count out of range");
    a_load_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> $past(o_in_pop))
        else $error("slice started without a word");
`endif

endmodule
